>>> src/hfed_pkg.sv
package hfed_pkg;

  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_ALPHA  = 2'd1,
    REG_SLOPE  = 2'd2,
    REG_OFFSET = 2'd3
  } reg_idx_t;

  localparam logic [15:0] PERIOD_RST = 16'd20;
  localparam logic [15:0] ALPHA_RST  = 16'd6237;
  localparam logic [15:0] SLOPE_RST  = 16'hED80;
  localparam logic [15:0] OFFSET_RST = 16'd24554;
  localparam logic [16:0] LN2_Q16    = 17'd45426;

  typedef struct packed {
    logic        start;
    logic        busy;
    logic        done;
  } ctl_t;

endpackage

>>> src/hfed_sqrt.sv
module hfed_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import hfed_pkg::*;

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= radicand;
        res  <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> src/hfed_log.sv
module hfed_log (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] mag,
  output logic        done,
  output logic signed [21:0] l2
);
  import hfed_pkg::*;

  logic [3:0]  e;
  logic [16:0] m;
  logic [15:0] frac;
  logic [4:0]  cnt;
  logic        busy;
  logic [33:0] sq;
  logic [18:0] msq;
  logic [3:0]  e_c;

  always_comb begin
    e_c = '0;
    for (int i = 1; i < 16; i++) begin
      if (mag[i]) e_c = 4'(i);
    end
  end

  assign sq  = m * m;
  assign msq = sq[33:15];
  assign l2  = $signed({2'b00, e, frac}) - $signed(22'(7 << 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        e    <= e_c;
        m    <= 17'({1'b0, mag} << (4'd15 - e_c));
        frac <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (msq >= 19'd65536) begin
          m    <= msq[17:1];
          frac <= {frac[14:0], 1'b1};
        end else begin
          m    <= msq[16:0];
          frac <= {frac[14:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> src/hall_field_ema_diameter.sv
// channel | signals                                         | dir
// cfg     | cfg_valid cfg_ready cfg_index cfg_data          | in
// in      | in_valid in_ready time_ms read_ok field_x/y/z   | in
// out     | out_valid out_ready magnitude diameter fresh    | out
// A fresh item passes through three EMA steps on one multiplier, three squares,
// a 32-step square root and 16 log squarings.
// A stale item passes through the log and scaling only.
// Synchronous reset restores register defaults and floor magnitude.
// The result register holds until taken; no item is accepted meanwhile.
module hall_field_ema_diameter #(
  parameter int FIELD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   time_ms,
  input  logic                          read_ok,
  input  logic signed [FIELD_WIDTH-1:0] field_x,
  input  logic signed [FIELD_WIDTH-1:0] field_y,
  input  logic signed [FIELD_WIDTH-1:0] field_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   magnitude,
  output logic signed [15:0]            diameter,
  output logic                          fresh
);
  import hfed_pkg::*;

  localparam int AF = 32 - FIELD_WIDTH;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_EMA  = 8'b00000010, S_SQ   = 8'b00000100,
    S_SQRT = 8'b00001000, S_LOG  = 8'b00010000, S_LN   = 8'b00100000,
    S_DIA  = 8'b01000000, S_OUT  = 8'b10000000
  } state_t;

  state_t state;
  logic [15:0] period, alpha;
  logic signed [15:0] slope, offset;
  logic [31:0] last_time;
  logic seeded, ok;
  logic signed [31:0] avg [3];
  logic signed [FIELD_WIDTH-1:0] fld [3];
  logic [15:0] held;
  logic [1:0] ax;
  logic [63:0] acc;
  logic sq_start, lg_start, sq_done, lg_done;
  logic [31:0] root;
  logic signed [21:0] l2;
  logic signed [32:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [56:0] mul_p;
  logic signed [32:0] diff;
  logic signed [31:0] xs;
  logic [32:0] magr;
  logic signed [23:0] lnv;
  logic signed [40:0] dsum;

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_ready  = (state == S_IDLE) && !out_valid;

  assign xs   = 32'(fld[ax]) <<< AF;
  assign diff = 33'(xs) - 33'(avg[ax]);
  assign mul_p = 57'(mul_a) * 57'(mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_EMA: begin
        mul_a = diff;
        mul_b = 24'($signed({1'b0, alpha}));
      end
      S_LN: begin
        mul_a = 33'(l2);
        mul_b = 24'($signed(LN2_Q16));
      end
      S_DIA: begin
        mul_a = 33'(slope);
        mul_b = lnv;
      end
      default: ;
    endcase
  end

  logic [32:0] sq_abs;
  logic [63:0] sq_p;
  assign sq_abs = avg[ax][31] ? 33'(-33'(avg[ax])) : 33'(avg[ax]);
  assign sq_p   = sq_abs[31:0] * sq_abs[31:0];

  assign magr = 33'(root) + 33'(33'd1 << (AF - 1));

  hfed_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(acc),
    .done(sq_done), .root(root)
  );

  hfed_log u_log (
    .clk(clk), .rst(rst), .start(lg_start), .mag(held),
    .done(lg_done), .l2(l2)
  );

  logic signed [47:0] step;
  assign step = 48'(mul_p + 57'sd32768) >>> 16;
  assign dsum = 41'(step) + 41'(offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      period    <= PERIOD_RST;
      alpha     <= ALPHA_RST;
      slope     <= SLOPE_RST;
      offset    <= OFFSET_RST;
      last_time <= '0;
      seeded    <= 1'b0;
      avg[0]    <= '0;
      avg[1]    <= '0;
      avg[2]    <= '0;
      held      <= 16'd1;
      out_valid <= 1'b0;
      sq_start  <= 1'b0;
      lg_start  <= 1'b0;
    end else begin
      sq_start <= 1'b0;
      lg_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
              REG_PERIOD: period <= cfg_data;
              REG_ALPHA:  alpha  <= cfg_data;
              REG_SLOPE:  slope  <= cfg_data;
              REG_OFFSET: offset <= cfg_data;
              default: ;
            endcase
          end
          if (in_valid && in_ready) begin
            fld[0] <= field_x;
            fld[1] <= field_y;
            fld[2] <= field_z;
            ok     <= read_ok;
            ax     <= '0;
            acc    <= '0;
            if ((time_ms - last_time) >= {16'd0, period}) begin
              fresh     <= 1'b1;
              last_time <= time_ms;
              state     <= S_EMA;
            end else begin
              fresh    <= 1'b0;
              lg_start <= 1'b1;
              state    <= S_LOG;
            end
          end
        end
        S_EMA: begin
          if (ok) begin
            avg[ax] <= seeded ? avg[ax] + step[31:0] : xs;
          end
          if (ax == 2'd2) begin
            ax <= '0;
            if (ok) seeded <= 1'b1;
            state <= S_SQ;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        S_SQ: begin
          acc <= acc + sq_p;
          if (ax == 2'd2) begin
            sq_start <= 1'b1;
            state    <= S_SQRT;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            if ((magr >> AF) > 33'd65535) held <= 16'hFFFF;
            else if ((magr >> AF) == 33'd0) held <= 16'd1;
            else held <= 16'(magr >> AF);
            lg_start <= 1'b1;
            state    <= S_LOG;
          end
        end
        S_LOG: begin
          if (lg_done) state <= S_LN;
        end
        S_LN: begin
          lnv   <= step[23:0];
          state <= S_DIA;
        end
        S_DIA: begin
          if (dsum > 41'sd32767) diameter <= 16'sh7FFF;
          else if (dsum < -41'sd32768) diameter <= 16'sh8000;
          else diameter <= dsum[15:0];
          magnitude <= held;
          state     <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> tb/tb.sv
module tb;
  import hfed_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0]        t;
    logic               ok;
    logic signed [15:0] x, y, z;
  } sample_t;

  typedef struct {
    logic [15:0]        mag;
    logic signed [15:0] dia;
    logic               fresh;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_idx_t cfg_index = REG_PERIOD;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] time_ms = '0;
  logic read_ok = 1'b0;
  logic signed [15:0] field_x = '0, field_y = '0, field_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] magnitude;
  logic signed [15:0] diameter;
  logic fresh;

  hall_field_ema_diameter dut (.*);

  always #2 clk = ~clk;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int errs = 0;
  int idle_cycles = 0;
  int long_hold_req = 0;
  logic in_taken = 1'b0;

  // model state
  logic [15:0] m_period, m_alpha;
  logic signed [15:0] m_slope, m_offset;
  logic [31:0] m_last;
  logic m_seeded;
  int m_avg[3];
  logic [15:0] m_mag;
  logic [31:0] t_cursor = '0;

  function automatic logic [15:0] filtered_magnitude();
    longint unsigned sum, a, res, bitv, n;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      a = (m_avg[i] < 0) ? longint'(-longint'(m_avg[i])) : longint'(m_avg[i]);
      sum += a * a;
    end
    n = sum;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    res = (res + 64'd32768) >> 16;
    if (res > 65535) res = 65535;
    if (res < 1) res = 1;
    return res[15:0];
  endfunction

  function automatic logic signed [15:0] diameter_of(logic [15:0] mag);
    int e;
    longint unsigned m;
    longint l2, lnv, d;
    logic [15:0] frac;
    e = 0;
    frac = '0;
    if (mag == 0) mag = 1;
    while (e < 15 && (mag >> (e + 1)) != 0) e++;
    m = longint'(mag) << (15 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        frac[0] = 1'b1;
        m >>= 1;
      end
    end
    l2 = (longint'(e) << 16) + longint'(frac) - (longint'(7) << 16);
    lnv = (l2 * 45426 + 32768) >>> 16;
    d = ((longint'(m_slope) * lnv + 32768) >>> 16) + longint'(m_offset);
    if (d > 32767) d = 32767;
    if (d < -32768) d = -32768;
    return d[15:0];
  endfunction

  function automatic reading_t filter_step(sample_t s);
    reading_t r;
    longint xs, diff, stepv;
    logic signed [15:0] f[3];
    f[0] = s.x; f[1] = s.y; f[2] = s.z;
    r.fresh = 1'b0;
    if (s.t - m_last >= {16'd0, m_period}) begin
      r.fresh = 1'b1;
      m_last = s.t;
      if (s.ok) begin
        for (int i = 0; i < 3; i++) begin
          xs = longint'(f[i]) * 65536;
          if (!m_seeded) begin
            m_avg[i] = int'(xs);
          end else begin
            diff = xs - longint'(m_avg[i]);
            stepv = (diff * longint'(m_alpha) + 32768) >>> 16;
            m_avg[i] = int'(longint'(m_avg[i]) + stepv);
          end
        end
        m_seeded = 1'b1;
      end
      m_mag = filtered_magnitude();
    end
    r.mag = m_mag;
    r.dia = diameter_of(m_mag);
    return r;
  endfunction

  // sender: bursts and gaps
  int burst_left = 0, gap_left = 0;
  logic hold_input = 1'b0;
  always @(negedge clk) begin
    sample_t s;
    logic nv;
    nv = in_valid && !in_taken;
    if (!nv && !rst && !hold_input) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        time_ms <= s.t; read_ok <= s.ok;
        field_x <= s.x; field_y <= s.y; field_z <= s.z;
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid <= nv;
  end

  // receiver: stall pattern plus long hold-off
  int hold_left = 0, hold_seen = 0, mode_left = 0, stall_mode = 0;
  always @(negedge clk) begin
    if (long_hold_req != hold_seen) begin
      hold_seen = long_hold_req;
      hold_left = 400;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(16, 128);
      stall_mode = $urandom_range(0, 3);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // check results and record accepted items
  always @(posedge clk) begin
    sample_t s;
    reading_t want;
    in_taken <= in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      s.t = time_ms; s.ok = read_ok; s.x = field_x; s.y = field_y; s.z = field_z;
      expected_readings.push_back(filter_step(s));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected item: mag %0d dia %0d", magnitude, diameter);
      end else begin
        want = expected_readings.pop_front();
        if (want.mag !== magnitude || want.dia !== diameter || want.fresh !== fresh) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: exp mag %0d dia %0d fresh %0b, got mag %0d dia %0d fresh %0b",
                     want.mag, want.dia, want.fresh, magnitude, diameter, fresh);
        end
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= 5000) begin
      $display("tb NOT OK");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PERIOD: m_period = val;
      REG_ALPHA:  m_alpha = val;
      REG_SLOPE:  m_slope = val;
      default:    m_offset = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(logic [31:0] dt, logic ok, logic signed [15:0] x,
                          logic signed [15:0] y, logic signed [15:0] z);
    sample_t s;
    t_cursor += dt;
    s.t = t_cursor; s.ok = ok; s.x = x; s.y = y; s.z = z;
    pending_samples.push_back(s);
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
      @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic random_items(int count);
    logic signed [15:0] v[3];
    int r;
    logic [31:0] dt;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 9);
      if (r < 6) dt = m_period + $urandom_range(0, 5);
      else if (r < 9) dt = $urandom_range(0, m_period);
      else dt = $urandom;
      for (int i = 0; i < 3; i++)
        v[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 511)) - 16'sd256
                                            : 16'($urandom);
      add_item(dt, $urandom_range(0, 7) != 0, v[0], v[1], v[2]);
    end
  endtask

  initial begin
    m_period = PERIOD_RST; m_alpha = ALPHA_RST;
    m_slope = SLOPE_RST; m_offset = OFFSET_RST;
    m_last = '0; m_seeded = 1'b0; m_avg = '{0, 0, 0}; m_mag = 16'd1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // accepted before any good read, failed reads, stale items, extremes
    add_item(32'd5, 1'b1, 16'sd100, 16'sd100, 16'sd100);
    add_item(32'd20, 1'b0, 16'sd500, 16'sd0, 16'sd0);
    add_item(32'd20, 1'b1, -16'sd32768, -16'sd32768, -16'sd32768);
    add_item(32'd3, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    add_item(32'd25, 1'b1, 16'sd32767, 16'sd32767, 16'sd32767);
    add_item(32'd20, 1'b0, 16'sd0, 16'sd0, 16'sd0);
    add_item(32'd21, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    add_item(32'd20, 1'b1, 16'sd1, -16'sd1, 16'sd0);
    add_item(32'hFFFF_FFF0, 1'b1, 16'sd128, 16'sd0, 16'sd0);
    add_item(32'h0000_0030, 1'b1, -16'sd1, 16'sd0, 16'sd0);
    add_item(32'd19, 1'b1, 16'sd1000, 16'sd2000, -16'sd3000);
    drain();

    write_reg(REG_PERIOD, 16'd0);
    write_reg(REG_ALPHA, 16'd0);
    add_item(32'd0, 1'b1, 16'sd32767, -16'sd32768, 16'sd5);
    add_item(32'd0, 1'b1, 16'sd1, 16'sd2, 16'sd3);
    random_items(200);
    drain();

    write_reg(REG_ALPHA, 16'hFFFF);
    write_reg(REG_SLOPE, 16'h8000);
    write_reg(REG_OFFSET, 16'h8000);
    write_reg(REG_PERIOD, 16'd1);
    long_hold_req++;
    random_items(200);
    drain();

    write_reg(REG_SLOPE, 16'h7FFF);
    write_reg(REG_OFFSET, 16'h7FFF);
    write_reg(REG_PERIOD, 16'hFFFF);
    random_items(200);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_PERIOD, (p == 0) ? PERIOD_RST : 16'($urandom_range(0, 100)));
      write_reg(REG_ALPHA, 16'($urandom));
      write_reg(REG_SLOPE, 16'($urandom));
      write_reg(REG_OFFSET, 16'($urandom));
      if (p == 2) long_hold_req++;
      random_items(220);
      drain();
    end

    if (errs == 0 && expected_readings.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end
endmodule
